[rtl/diff_drive_odometry_defines.svh]
// Assertion macros shared by the odometry RTL.
// Each check is sampled on the rising clock edge and disabled while reset is low.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication
`define DDO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("odometry check failed");
// Next-cycle implication
`define DDO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("odometry check failed");
`else
`define DDO_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DDO_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/ddo_pkg.sv]
package ddo_pkg;

    // Datapath widths
    localparam int XW   = 44;   // rotation vector, 2^-40
    localparam int ZW   = 36;   // rotation angle, 2^-32 rad
    localparam int HW   = 35;   // heading output
    localparam int AW   = 48;   // accumulators
    localparam int REGW = 24;   // configuration registers
    localparam int CSW  = 34;   // cos and sin, 2^-30

    // Angle constants in 2^-32 rad
    localparam logic signed [ZW-1:0] PI_S      = 36'sd13493037705;
    localparam logic signed [ZW-1:0] HALF_PI_S = 36'sd6746518852;
    localparam logic [ZW-1:0] PI_U       = 36'd13493037705;
    localparam logic [ZW-1:0] TWO_PI_U   = 36'd26986075409;
    localparam logic [ZW-1:0] THREE_PI_U = 36'd40479113114;

    // Rotation start gain in 2^-40
    localparam logic signed [XW-1:0] GAIN_Q40 = 44'sd667681663083;

    // Accumulator limits
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    // Register map, word index
    localparam logic [1:0] REG_RIGHT_MPT = 2'd0;
    localparam logic [1:0] REG_LEFT_MPT  = 2'd1;
    localparam logic [1:0] REG_INV_SEP   = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SCALE,
        ST_DIFF,
        ST_ABS,
        ST_HMUL,
        ST_HSUM,
        ST_HMOD,
        ST_HNEG,
        ST_HADD,
        ST_LAUNCH,
        ST_ROT,
        ST_PABS,
        ST_PMUL,
        ST_PSUM,
        ST_PSIGN,
        ST_COMMIT
    } ddo_state_t;

    // Vector handed from one rotation cell to the next
    typedef struct packed {
        logic                 flip;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } ddo_vec_t;

    // atan(2^-idx) in 2^-32 rad, rounded
    function automatic logic signed [ZW-1:0] atan_q32(input int unsigned idx);
        logic signed [ZW-1:0] r;
        r = '0;
        case (idx)
            0:  r = 36'sd3373259426;
            1:  r = 36'sd1991351318;
            2:  r = 36'sd1052175346;
            3:  r = 36'sd534100635;
            4:  r = 36'sd268086748;
            5:  r = 36'sd134174063;
            6:  r = 36'sd67103403;
            7:  r = 36'sd33553749;
            8:  r = 36'sd16777131;
            9:  r = 36'sd8388597;
            10: r = 36'sd4194303;
            default: begin
                if (idx <= 32) begin
                    r = ZW'(36'sd1 <<< (32 - idx));
                end else if (idx == 33) begin
                    // half an LSB rounds up
                    r = 36'sd1;
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/ddo_cordic_cell.sv]
module ddo_cordic_cell import ddo_pkg::*; #(
    parameter int unsigned STAGE = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  ddo_vec_t in_vec,
    output logic     out_valid,
    output ddo_vec_t out_vec
);

    localparam logic signed [ZW-1:0] ATAN = atan_q32(STAGE);

    logic            valid_reg;
    ddo_vec_t        vec_reg;
    ddo_vec_t        vec_next;
    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    // One micro-rotation toward zero angle
    always_comb begin
        xi = in_vec.x;
        yi = in_vec.y;
        zi = in_vec.z;
        xs = xi >>> STAGE;
        ys = yi >>> STAGE;
        vec_next.flip = in_vec.flip;
        if (!zi[ZW-1]) begin
            vec_next.x = xi - ys;
            vec_next.y = yi + xs;
            vec_next.z = zi - ATAN;
        end else begin
            vec_next.x = xi + ys;
            vec_next.y = yi - xs;
            vec_next.z = zi + ATAN;
        end
    end

    // Advance the valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    // Hand the vector on every cycle
    always_ff @(posedge aclk) begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

[rtl/ddo_cordic_chain.sv]
module ddo_cordic_chain import ddo_pkg::*; #(
    parameter int STEPS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [HW-1:0]  heading,
    output logic                  done,
    output logic signed [CSW-1:0] cos_q30,
    output logic signed [CSW-1:0] sin_q30
);

    logic     valid_tap [STEPS+1];
    ddo_vec_t vec_tap   [STEPS+1];
    logic signed [ZW-1:0] h_ext;
    logic signed [XW-1:0] x_end;
    logic signed [XW-1:0] y_end;
    logic signed [XW-1:0] x_fix;
    logic signed [XW-1:0] y_fix;

    // Fold the angle into the right half plane
    always_comb begin
        h_ext = ZW'(heading);
        vec_tap[0].x = GAIN_Q40;
        vec_tap[0].y = '0;
        if (h_ext > HALF_PI_S) begin
            vec_tap[0].z    = h_ext - PI_S;
            vec_tap[0].flip = 1'b1;
        end else if (h_ext < -HALF_PI_S) begin
            vec_tap[0].z    = h_ext + PI_S;
            vec_tap[0].flip = 1'b1;
        end else begin
            vec_tap[0].z    = h_ext;
            vec_tap[0].flip = 1'b0;
        end
        valid_tap[0] = start;
    end

    // Row of rotation cells
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        ddo_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_tap[g]),
            .in_vec    (vec_tap[g]),
            .out_valid (valid_tap[g+1]),
            .out_vec   (vec_tap[g+1])
        );
    end

    // Undo the fold and drop to 2^-30
    always_comb begin
        x_end = vec_tap[STEPS].x;
        y_end = vec_tap[STEPS].y;
        x_fix = vec_tap[STEPS].flip ? -x_end : x_end;
        y_fix = vec_tap[STEPS].flip ? -y_end : y_end;
    end

    assign done    = valid_tap[STEPS];
    assign cos_q30 = CSW'(x_fix >>> 10);
    assign sin_q30 = CSW'(y_fix >>> 10);

endmodule

[rtl/diff_drive_odometry.sv]
// Differential-drive wheel odometry.
// Input stream: s_tdata carries the left and right encoder readings, s_tuser the
// mode (0 update the pose, 1 clear the pose and latch the readings). Every input
// transaction yields exactly one output transaction on m_tdata with x, y, heading
// and both wheel travel totals as they stand after that item.
// Configuration: an APB port with wheel scale factors and inverse wheel separation
// at word addresses 0, 1 and 2; write only while no item is in flight.
// Timing: one item is worked at a time. An update passes from acceptance through the
// iterative modulo-2*pi reduction of the heading change and the row of rotation
// cells to a valid result. A clear item goes from acceptance straight to the commit
// state, where it waits, like an update, until the output register is free.
// s_tready is high only while the sequencer waits for an item.
// The result sits in an output register; the next item is accepted while it waits,
// and that item's results are held back until the receiver takes the previous one.
// Reset: aresetn low clears the pose, totals, latched readings and valid flags, and
// loads the register defaults.
`include "diff_drive_odometry_defines.svh"
module diff_drive_odometry import ddo_pkg::*; #(
    parameter int COUNTER_BITS = 16,
    parameter int CORDIC_STEPS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // left_count[15:0], right_count[31:16]
    input  logic         s_tuser,   // mode
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata,   // x_position[47:0], y_position[95:48],
                                    // heading[130:96], left_travel[178:131],
                                    // right_travel[226:179], zero[231:227]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W     = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;
    localparam bit WRAP      = (COUNTER_BITS <= 16);
    localparam int DW        = CNT_W + 1;      // count change
    localparam int SW        = DW + REGW;      // wheel step
    localparam int QW        = SW + 8;         // heading change before reduction
    localparam int MOD_STEPS = QW - 34;
    localparam int KW        = $clog2(MOD_STEPS);
    localparam int LO        = 20;             // split of the mean step
    localparam int RW        = SW + 1;         // position step magnitude

    localparam logic signed [CNT_W+1:0] FULL_CNT = (CNT_W+2)'(1) <<< CNT_W;
    localparam logic signed [CNT_W+1:0] HALF_CNT = FULL_CNT >>> 1;

    // configuration registers
    logic [REGW-1:0] rmpt_reg;
    logic [REGW-1:0] lmpt_reg;
    logic [REGW-1:0] inv_reg;

    // sequencer
    ddo_state_t state_reg;
    ddo_state_t state_next;
    logic       commit_en;
    logic       chain_start;
    logic       chain_done;

    // item and step registers
    logic [CNT_W-1:0]        lc_reg;
    logic [CNT_W-1:0]        rc_reg;
    logic                    mode_reg;
    logic signed [DW-1:0]    dl_delta_reg;
    logic signed [DW-1:0]    dr_delta_reg;
    logic signed [SW-1:0]    dl_reg;
    logic signed [SW-1:0]    dr_reg;
    logic signed [SW-1:0]    mean_reg;
    logic signed [SW:0]      diff_reg;
    logic [SW-1:0]           mag_reg;
    logic                    neg_reg;
    logic [SW-1:0]           mean_mag_reg;
    logic                    mean_neg_reg;
    logic [SW-1:0]           p1_reg;
    logic [47:0]             p2_reg;
    logic [QW-1:0]           q_reg;
    logic [KW-1:0]           k_reg;
    logic [ZW-1:0]           hadd_reg;
    logic [ZW-1:0]           hp_reg;
    logic signed [HW-1:0]    hnew_reg;
    logic signed [CSW-1:0]   c_reg;
    logic signed [CSW-1:0]   s_reg;
    logic [CSW-1:0]          cm_reg;
    logic [CSW-1:0]          sm_reg;
    logic                    cneg_reg;
    logic                    sneg_reg;
    logic [SW-LO+CSW-1:0]    pxh_reg;
    logic [LO+CSW-1:0]       pxl_reg;
    logic [SW-LO+CSW-1:0]    pyh_reg;
    logic [LO+CSW-1:0]       pyl_reg;
    logic [RW-1:0]           rx_reg;
    logic [RW-1:0]           ry_reg;
    logic signed [RW:0]      stepx_reg;
    logic signed [RW:0]      stepy_reg;

    // pose state
    logic [CNT_W-1:0]     lprev_reg;
    logic [CNT_W-1:0]     rprev_reg;
    logic signed [AW-1:0] xacc_reg;
    logic signed [AW-1:0] yacc_reg;
    logic signed [AW-1:0] lacc_reg;
    logic signed [AW-1:0] racc_reg;
    logic signed [HW-1:0] hacc_reg;
    logic signed [AW-1:0] xacc_next;
    logic signed [AW-1:0] yacc_next;
    logic signed [AW-1:0] lacc_next;
    logic signed [AW-1:0] racc_next;
    logic signed [HW-1:0] hacc_next;

    // output register
    logic         m_tvalid_reg;
    logic [231:0] m_data_reg;

    // datapath combinational values
    logic signed [DW-1:0]    dl_delta_next;
    logic signed [DW-1:0]    dr_delta_next;
    logic signed [SW:0]      sum_next;
    logic [QW:0]             sub_next;
    logic [ZW-1:0]           t_next;
    logic signed [SW+LO+CSW:0] sumx_next;
    logic signed [SW+LO+CSW:0] sumy_next;
    logic signed [CSW-1:0]   cos_q30;
    logic signed [CSW-1:0]   sin_q30;

    // wrap a raw count change into one half turn either way
    function automatic logic signed [DW-1:0] wrap_delta(input logic signed [CNT_W+1:0] raw);
        logic signed [CNT_W+1:0] d;
        d = raw;
        if (WRAP) begin
            if (d > HALF_CNT) begin
                d = d - FULL_CNT;
            end else if (d < -HALF_CNT) begin
                d = d + FULL_CNT;
            end
        end
        return DW'(d);
    endfunction

    // add and clamp to the accumulator range
    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW:0] b);
        logic signed [AW:0] s;
        s = (AW+1)'(a) + b;
        if (s[AW] != s[AW-1]) begin
            return s[AW] ? ACC_MIN : ACC_MAX;
        end
        return AW'(s);
    endfunction

    // rotation row
    ddo_cordic_chain #(
        .STEPS (CORDIC_STEPS)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (chain_start),
        .heading (hnew_reg),
        .done    (chain_done),
        .cos_q30 (cos_q30),
        .sin_q30 (sin_q30)
    );

    // next state and handshake
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        chain_start = 1'b0;
        commit_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = s_tuser ? ST_COMMIT : ST_DELTA;
                end
            end
            ST_DELTA:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_ABS;
            ST_ABS:    state_next = ST_HMUL;
            ST_HMUL:   state_next = ST_HSUM;
            ST_HSUM:   state_next = ST_HMOD;
            ST_HMOD: begin
                if (k_reg == '0) begin
                    state_next = ST_HNEG;
                end
            end
            ST_HNEG:   state_next = ST_HADD;
            ST_HADD:   state_next = ST_LAUNCH;
            ST_LAUNCH: begin
                chain_start = 1'b1;
                state_next  = ST_ROT;
            end
            ST_ROT: begin
                if (chain_done) begin
                    state_next = ST_PABS;
                end
            end
            ST_PABS:   state_next = ST_PMUL;
            ST_PMUL:   state_next = ST_PSUM;
            ST_PSUM:   state_next = ST_PSIGN;
            ST_PSIGN:  state_next = ST_COMMIT;
            ST_COMMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    commit_en  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // combinational datapath pieces
    always_comb begin
        dl_delta_next = wrap_delta(signed'({2'b00, lc_reg}) - signed'({2'b00, lprev_reg}));
        dr_delta_next = wrap_delta(signed'({2'b00, rc_reg}) - signed'({2'b00, rprev_reg}));
        sum_next      = (SW+1)'(dr_reg) + (SW+1)'(dl_reg);
        sub_next      = (QW+1)'(TWO_PI_U) << k_reg;
        t_next        = hp_reg + hadd_reg;
        sumx_next     = signed'({1'b0, pxh_reg, {LO{1'b0}}}) + (SW+LO+CSW+1)'(pxl_reg);
        sumy_next     = signed'({1'b0, pyh_reg, {LO{1'b0}}}) + (SW+LO+CSW+1)'(pyl_reg);
    end

    // working registers, one step per state
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                lc_reg   <= s_tdata[CNT_W-1:0];
                rc_reg   <= s_tdata[16 +: CNT_W];
                mode_reg <= s_tuser;
            end
            ST_DELTA: begin
                dl_delta_reg <= dl_delta_next;
                dr_delta_reg <= dr_delta_next;
            end
            ST_SCALE: begin
                dl_reg <= SW'(dl_delta_reg) * SW'(signed'({1'b0, lmpt_reg}));
                dr_reg <= SW'(dr_delta_reg) * SW'(signed'({1'b0, rmpt_reg}));
            end
            ST_DIFF: begin
                mean_reg <= sum_next[SW:1];
                diff_reg <= (SW+1)'(dr_reg) - (SW+1)'(dl_reg);
            end
            ST_ABS: begin
                neg_reg      <= diff_reg[SW];
                mag_reg      <= diff_reg[SW] ? SW'(-diff_reg) : SW'(diff_reg);
                mean_neg_reg <= mean_reg[SW-1];
                mean_mag_reg <= mean_reg[SW-1] ? SW'(-mean_reg) : SW'(mean_reg);
            end
            ST_HMUL: begin
                p1_reg <= SW'(mag_reg[SW-1:REGW] * inv_reg);
                p2_reg <= mag_reg[REGW-1:0] * inv_reg;
            end
            ST_HSUM: begin
                q_reg <= {p1_reg, 8'b0} + QW'(p2_reg[47:16]);
                k_reg <= KW'(MOD_STEPS - 1);
            end
            ST_HMOD: begin
                // restoring reduction modulo 2*pi, one shift per cycle
                if ({1'b0, q_reg} >= sub_next) begin
                    q_reg <= QW'({1'b0, q_reg} - sub_next);
                end
                k_reg <= k_reg - KW'(1);
            end
            ST_HNEG: begin
                hadd_reg <= neg_reg ? TWO_PI_U - ZW'(q_reg[34:0]) : ZW'(q_reg[34:0]);
                hp_reg   <= ZW'(ZW'(hacc_reg) + PI_S);
            end
            ST_HADD: begin
                hnew_reg <= (t_next >= TWO_PI_U) ? HW'(t_next - THREE_PI_U)
                                                 : HW'(t_next - PI_U);
            end
            ST_ROT: begin
                c_reg <= cos_q30;
                s_reg <= sin_q30;
            end
            ST_PABS: begin
                cneg_reg <= c_reg[CSW-1];
                sneg_reg <= s_reg[CSW-1];
                cm_reg   <= c_reg[CSW-1] ? CSW'(-c_reg) : CSW'(c_reg);
                sm_reg   <= s_reg[CSW-1] ? CSW'(-s_reg) : CSW'(s_reg);
            end
            ST_PMUL: begin
                pxh_reg <= mean_mag_reg[SW-1:LO] * cm_reg;
                pxl_reg <= mean_mag_reg[LO-1:0] * cm_reg;
                pyh_reg <= mean_mag_reg[SW-1:LO] * sm_reg;
                pyl_reg <= mean_mag_reg[LO-1:0] * sm_reg;
            end
            ST_PSUM: begin
                rx_reg <= sumx_next[30 +: RW];
                ry_reg <= sumy_next[30 +: RW];
            end
            ST_PSIGN: begin
                stepx_reg <= (mean_neg_reg ^ cneg_reg) ? -signed'({1'b0, rx_reg})
                                                       : signed'({1'b0, rx_reg});
                stepy_reg <= (mean_neg_reg ^ sneg_reg) ? -signed'({1'b0, ry_reg})
                                                       : signed'({1'b0, ry_reg});
            end
            default: begin
            end
        endcase
    end

    // new pose for the commit
    always_comb begin
        if (mode_reg) begin
            xacc_next = '0;
            yacc_next = '0;
            lacc_next = '0;
            racc_next = '0;
            hacc_next = '0;
        end else begin
            xacc_next = sat_add(xacc_reg, (AW+1)'(stepx_reg));
            yacc_next = sat_add(yacc_reg, (AW+1)'(stepy_reg));
            lacc_next = sat_add(lacc_reg, (AW+1)'(dl_reg));
            racc_next = sat_add(racc_reg, (AW+1)'(dr_reg));
            hacc_next = hnew_reg;
        end
    end

    // pose state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lprev_reg    <= '0;
            rprev_reg    <= '0;
            xacc_reg     <= '0;
            yacc_reg     <= '0;
            lacc_reg     <= '0;
            racc_reg     <= '0;
            hacc_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (commit_en) begin
                lprev_reg    <= lc_reg;
                rprev_reg    <= rc_reg;
                xacc_reg     <= xacc_next;
                yacc_reg     <= yacc_next;
                lacc_reg     <= lacc_next;
                racc_reg     <= racc_next;
                hacc_reg     <= hacc_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // capture the result transaction
    always_ff @(posedge aclk) begin
        if (commit_en) begin
            m_data_reg <= {5'b0, racc_next, lacc_next, hacc_next, yacc_next, xacc_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rmpt_reg <= 24'd440012;
            lmpt_reg <= 24'd440012;
            inv_reg  <= 24'd252062;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_RIGHT_MPT: rmpt_reg <= pwdata[REGW-1:0];
                REG_LEFT_MPT:  lmpt_reg <= pwdata[REGW-1:0];
                REG_INV_SEP:   inv_reg  <= pwdata[REGW-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_RIGHT_MPT: prdata = {8'b0, rmpt_reg};
            REG_LEFT_MPT:  prdata = {8'b0, lmpt_reg};
            REG_INV_SEP:   prdata = {8'b0, inv_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // checks
    `DDO_ASSERT_IMP(a_heading_range, aclk, aresetn, 1'b1, (ZW'(hacc_reg) >= -PI_S) && (ZW'(hacc_reg) < PI_S))
    `DDO_ASSERT_NXT(a_commit_waits, aclk, aresetn, (state_reg == ST_COMMIT) && m_tvalid_reg && !m_tready, state_reg == ST_COMMIT)
    `DDO_ASSERT_IMP(a_rot_done, aclk, aresetn, chain_done, state_reg == ST_ROT)
    `DDO_ASSERT_NXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import ddo_pkg::*;

    // One result transaction as it appears on m_tdata
    typedef struct {
        logic [47:0] x_pos;
        logic [47:0] y_pos;
        logic [34:0] heading;
        logic [47:0] left_trav;
        logic [47:0] right_trav;
    } pose_t;

    // Pose tracker: mirrors the odometry state and holds pending poses
    class odo_scoreboard;
        localparam longint PI_Q   = 64'sd13493037705;
        localparam longint HALF_Q = 64'sd6746518852;
        localparam longint TWO_Q  = 64'sd26986075409;
        localparam longint GAIN   = 64'sd667681663083;
        localparam longint LIM_HI = 64'sd140737488355327;
        localparam longint LIM_LO = -64'sd140737488355328;

        longint unsigned right_scale, left_scale, inv_sep;
        longint unsigned left_last, right_last;
        longint left_dist, right_dist, x_acc, y_acc, head_acc;
        longint atan_tab[32];
        pose_t pending_poses[$];
        int errors;

        function new();
            right_scale = 440012;
            left_scale  = 440012;
            inv_sep     = 252062;
            left_last = 0; right_last = 0;
            left_dist = 0; right_dist = 0;
            x_acc = 0; y_acc = 0; head_acc = 0;
            errors = 0;
            for (int i = 0; i < 32; i++) atan_tab[i] = arctan_step(i);
        endfunction

        // arctan(2^-i) in 2^-32 rad from an integer series in 2^-60
        function longint arctan_step(int i);
            longint unsigned s, p, k, t;
            s = 0;
            if (i == 0) begin
                // atan(1) = atan(1/2) + atan(1/3)
                p = 64'd1 << 59;
                for (k = 0; p != 0; k++) begin
                    t = p / (2 * k + 1);
                    s = k[0] ? s - t : s + t;
                    p = p >> 2;
                end
                p = (64'd1 << 60) / 3;
                for (k = 0; p != 0; k++) begin
                    t = p / (2 * k + 1);
                    s = k[0] ? s - t : s + t;
                    p = p / 9;
                end
            end else begin
                p = 64'd1 << (60 - i);
                for (k = 0; p != 0; k++) begin
                    t = p / (2 * k + 1);
                    s = k[0] ? s - t : s + t;
                    if (2 * i >= 60) p = 0;
                    else p = p >> (2 * i);
                end
            end
            return longint'((s + (64'd1 << 27)) >> 28);
        endfunction

        function longint clamp48(longint v);
            if (v > LIM_HI) return LIM_HI;
            if (v < LIM_LO) return LIM_LO;
            return v;
        endfunction

        // signed tick change, corrected for 16-bit counter wrap
        function longint tick_change(longint unsigned cur, longint unsigned prev);
            longint d;
            d = longint'(cur) - longint'(prev);
            if (d > 32768) d -= 65536;
            else if (d < -32768) d += 65536;
            return d;
        endfunction

        // m * f / 2^30, truncated toward zero
        function longint scale_q30(longint m, longint f);
            longint unsigned mm, fm, r;
            mm = (m < 0) ? longint'(-m) : m;
            fm = (f < 0) ? longint'(-f) : f;
            r = (mm >> 30) * fm + (((mm & 64'h3FFFFFFF) * fm) >> 30);
            return ((m < 0) != (f < 0)) ? -longint'(r) : longint'(r);
        endfunction

        // cos and sin in 2^-30 by rotation
        function void rotate(longint h, output longint c, output longint s);
            longint vx, vy, z, xs, ys;
            bit flip;
            vx = GAIN; vy = 0; z = h; flip = 0;
            if (z > HALF_Q) begin
                z -= PI_Q; flip = 1;
            end else if (z < -HALF_Q) begin
                z += PI_Q; flip = 1;
            end
            for (int i = 0; i < 32; i++) begin
                xs = vx >>> i;
                ys = vy >>> i;
                if (z >= 0) begin
                    vx -= ys; vy += xs; z -= atan_tab[i];
                end else begin
                    vx += ys; vy -= xs; z += atan_tab[i];
                end
            end
            if (flip) begin
                vx = -vx; vy = -vy;
            end
            c = vx >>> 10;
            s = vy >>> 10;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_RIGHT_MPT: right_scale = val[23:0];
                REG_LEFT_MPT:  left_scale  = val[23:0];
                REG_INV_SEP:   inv_sep     = val[23:0];
                default: ;
            endcase
        endfunction

        // Advance the pose for an accepted input transaction
        function void note_item(bit mode, logic [15:0] lc, logic [15:0] rc);
            longint dl, dr, mean, diff, c, s;
            longint unsigned mag, r, t, tp;
            pose_t p;
            tp = TWO_Q;
            if (mode) begin
                left_last = lc; right_last = rc;
                left_dist = 0; right_dist = 0;
                x_acc = 0; y_acc = 0; head_acc = 0;
            end else begin
                dr = tick_change(rc, right_last) * longint'(right_scale);
                dl = tick_change(lc, left_last) * longint'(left_scale);
                mean = (dr + dl) >>> 1;
                diff = dr - dl;
                mag = (diff < 0) ? longint'(-diff) : diff;
                right_last = rc;
                left_last = lc;
                right_dist = clamp48(right_dist + dr);
                left_dist = clamp48(left_dist + dl);
                // heading change reduced modulo 2*pi in two parts
                r = ((((mag >> 24) * inv_sep) % tp) << 8) % tp;
                r = (r + ((((mag & 64'hFFFFFF) * inv_sep) >> 16) % tp)) % tp;
                t = longint'(head_acc + PI_Q);
                t += (diff < 0) ? (tp - r) : r;
                t = t % tp;
                head_acc = longint'(t) - PI_Q;
                rotate(head_acc, c, s);
                x_acc = clamp48(x_acc + scale_q30(mean, c));
                y_acc = clamp48(y_acc + scale_q30(mean, s));
            end
            p.x_pos = x_acc[47:0];
            p.y_pos = y_acc[47:0];
            p.heading = head_acc[34:0];
            p.left_trav = left_dist[47:0];
            p.right_trav = right_dist[47:0];
            pending_poses.push_back(p);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // Compare one result transaction with the oldest pending pose
        task check_result(logic [231:0] d);
            pose_t p;
            if (pending_poses.size() == 0) begin
                report("result with no pending pose");
                return;
            end
            p = pending_poses.pop_front();
            if (d[47:0] !== p.x_pos)
                report($sformatf("x %h, want %h", d[47:0], p.x_pos));
            if (d[95:48] !== p.y_pos)
                report($sformatf("y %h, want %h", d[95:48], p.y_pos));
            if (d[130:96] !== p.heading)
                report($sformatf("heading %h, want %h", d[130:96], p.heading));
            if (d[178:131] !== p.left_trav)
                report($sformatf("left travel %h, want %h", d[178:131], p.left_trav));
            if (d[226:179] !== p.right_trav)
                report($sformatf("right travel %h, want %h", d[226:179], p.right_trav));
            if (d[231:227] !== 5'd0)
                report("pad bits not zero");
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;   // left_count[15:0], right_count[31:16]
    logic         s_tuser = 0;    // mode
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [231:0] m_tdata;        // x[47:0], y[95:48], heading[130:96],
                                  // left_travel[178:131], right_travel[226:179]
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    odo_scoreboard pose_sb = new();
    bit            calm = 0;
    bit            stall_request = 0;
    int            stall_left = 0;
    logic [15:0]   last_left = 0, last_right = 0;

    diff_drive_odometry dut (.*);

    always #4 aclk = ~aclk;

    // Receiver: random back-pressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (stall_request) begin
            stall_request = 0;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) pose_sb.check_result(m_tdata);
    end

    task apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        pose_sb.set_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one item, hold it until the block takes it, then withdraw it
    task send_item(bit mode, logic [15:0] lc, logic [15:0] rc);
        @(posedge aclk);
        s_tvalid <= 1; s_tuser <= mode; s_tdata <= {rc, lc};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 0;
        pose_sb.note_item(mode, lc, rc);
        last_left = lc;
        last_right = rc;
    endtask

    task sender_gap();
        int n;
        if (!calm && $urandom_range(99) < 27) begin
            n = $urandom_range(1, 6);
            repeat (n - 1) @(posedge aclk);
        end
    endtask

    // Drain all pending poses, then let the block settle
    task drain();
        while (pose_sb.pending_poses.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task random_item();
        int pick;
        logic [15:0] dl, dr;
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_item(1, 16'($urandom), 16'($urandom));
        end else if (pick < 65) begin
            // well-formed motion: small steps either way
            dl = 16'($urandom_range(200));
            dr = 16'($urandom_range(200));
            if ($urandom_range(1)) dl = -dl;
            if ($urandom_range(1)) dr = -dr;
            send_item(0, last_left + dl, last_right + dr);
        end else if (pick < 80) begin
            // near and at a half turn of the counter
            dl = 16'($urandom_range(32760, 32768));
            dr = 16'($urandom_range(32760, 32768));
            if ($urandom_range(1)) dl = -dl;
            if ($urandom_range(1)) dr = -dr;
            send_item(0, last_left + dl, last_right + dr);
        end else begin
            send_item(0, 16'($urandom), 16'($urandom));
        end
        sender_gap();
    endtask

    initial begin
        #(8 * 3_000_000);
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // Directed: default scale factors
        send_item(1, 16'hFFFF, 16'hFFFF);
        send_item(0, 16'hFFFF, 16'hFFFF);
        send_item(0, 16'h0009, 16'h0009);
        send_item(0, 16'h8009, 16'h0009);   // half turn forward, left
        send_item(0, 16'h0009, 16'h0009);   // half turn back
        send_item(0, 16'h0009, 16'h8009);
        send_item(0, 16'h0000, 16'h0000);
        send_item(0, 16'h7FFF, 16'h8001);
        send_item(0, 16'h0100, 16'hFF00);   // spin in place
        send_item(0, 16'hFFFF, 16'h0000);
        send_item(1, 16'h0000, 16'h0000);
        send_item(0, 16'h8000, 16'h8000);
        send_item(0, 16'h5555, 16'hAAAA);
        send_item(0, 16'hAAAA, 16'h5555);
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                1: begin
                    apb_write(REG_RIGHT_MPT, 32'hFFFFFF);
                    apb_write(REG_LEFT_MPT, 32'hFFFFFF);
                    apb_write(REG_INV_SEP, 32'hFFFFFF);
                end
                2: begin
                    apb_write(REG_RIGHT_MPT, 32'd0);
                    apb_write(REG_LEFT_MPT, 32'd0);
                    apb_write(REG_INV_SEP, 32'd1);
                end
                3: begin
                    apb_write(REG_RIGHT_MPT, 32'd440012);
                    apb_write(REG_LEFT_MPT, 32'hFFFFFF);
                    apb_write(REG_INV_SEP, 32'd0);   // heading stays put
                end
                default: if (phase > 0) begin
                    apb_write(REG_RIGHT_MPT, $urandom_range(24'hFFFFFF));
                    apb_write(REG_LEFT_MPT, $urandom_range(24'hFFFFFF));
                    apb_write(REG_INV_SEP, $urandom_range(1, 24'hFFFFFF));
                end
            endcase
            send_item(1, 16'($urandom), 16'($urandom));
            for (int n = 0; n < 270; n++) begin
                if (phase == 4) calm = (n >= 20 && n < 220);
                if (phase == 5 && n == 50) stall_request = 1;
                if (phase == 5 && n == 150) begin
                    // sender pause until the result side is empty
                    while (pose_sb.pending_poses.size() != 0) @(posedge aclk);
                end
                random_item();
            end
            calm = 0;
            drain();
        end

        if (pose_sb.pending_poses.size() != 0) pose_sb.report("poses left pending");
        if (pose_sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[diff_drive_odometry.f]
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_cordic_cell.sv
rtl/ddo_cordic_chain.sv
rtl/diff_drive_odometry.sv
tb/tb.sv
